// ===== design/bmtc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmtc_pkg
// Shared constants, codes and types of the bitmap text console renderer.
// ---------------------------------------------------------------------------
package bmtc_pkg;

    // font geometry
    localparam int GLYPH_ROWS  = 16;
    localparam int GLYPH_COUNT = 256;
    localparam int GLYPH_WIDTH = 8;

    localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);
    localparam int ROW_W      = $clog2(GLYPH_ROWS);
    localparam int RCNT_W     = $clog2(GLYPH_ROWS + 1);

    // field widths
    localparam int CMD_W    = 2;
    localparam int CODE_W   = 8;
    localparam int GROW_W   = 4;
    localparam int BITS_W   = 8;
    localparam int KIND_W   = 2;
    localparam int OFF_W    = 25;
    localparam int COLOR_W  = 32;
    localparam int SCR_W    = 13;
    localparam int PITCH_W  = 14;
    localparam int MARGIN_W = 7;
    localparam int CUR_W    = 13;
    localparam int CMP_W    = CUR_W + 2;
    localparam int PROD_W   = CUR_W + PITCH_W;

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 3;

    localparam logic [REG_W-1:0] REG_FG_COLOR      = 3'd0;
    localparam logic [REG_W-1:0] REG_BG_COLOR      = 3'd1;
    localparam logic [REG_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [REG_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
    localparam logic [REG_W-1:0] REG_LINE_PITCH    = 3'd4;
    localparam logic [REG_W-1:0] REG_MARGIN        = 3'd5;

    // register reset values
    localparam logic [COLOR_W-1:0]  FG_RST     = 32'hffff_ffff;
    localparam logic [COLOR_W-1:0]  BG_RST     = 32'h0000_0000;
    localparam logic [SCR_W-1:0]    WIDTH_RST  = 13'd640;
    localparam logic [SCR_W-1:0]    HEIGHT_RST = 13'd480;
    localparam logic [PITCH_W-1:0]  PITCH_RST  = 14'd640;
    localparam logic [MARGIN_W-1:0] MARGIN_RST = 7'd8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BKSP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_GLYPH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CODE_W-1:0]      NEWLINE_CODE = 8'd10;
    localparam logic [GLYPH_WIDTH-1:0] MASK_ALL     = 8'hff;

    typedef struct packed {
        logic [COLOR_W-1:0]  fg_color;
        logic [COLOR_W-1:0]  bg_color;
        logic [SCR_W-1:0]    screen_width;
        logic [SCR_W-1:0]    screen_height;
        logic [PITCH_W-1:0]  line_pitch;
        logic [MARGIN_W-1:0] margin;
    } cfg_t;

    typedef struct packed {
        logic                we;
        logic                re;
        logic [FONT_AW-1:0]  addr;
        logic [BITS_W-1:0]   wdata;
    } font_req_t;

endpackage
`default_nettype wire

// ===== design/bmtc_font_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmtc_font_ram
// Single-port glyph store, one row of eight pixels per entry, registered
// read data that holds until the next read.
// ---------------------------------------------------------------------------
module bmtc_font_ram
    import bmtc_pkg::*;
(
    input  wire logic              clk,
    input  wire font_req_t         req,
    output logic [BITS_W-1:0]      rdata
);

    logic [BITS_W-1:0] mem [FONT_DEPTH];
    logic [BITS_W-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/bmtc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmtc_cfg_regs
// APB-style register file for colours, screen geometry, pitch and margin.
// ---------------------------------------------------------------------------
module bmtc_cfg_regs
    import bmtc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t             cfg_reg;
    logic             wr_en;
    logic [REG_W-1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg_color      <= FG_RST;
            cfg_reg.bg_color      <= BG_RST;
            cfg_reg.screen_width  <= WIDTH_RST;
            cfg_reg.screen_height <= HEIGHT_RST;
            cfg_reg.line_pitch    <= PITCH_RST;
            cfg_reg.margin        <= MARGIN_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FG_COLOR:      cfg_reg.fg_color      <= pwdata;
                REG_BG_COLOR:      cfg_reg.bg_color      <= pwdata;
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= pwdata[SCR_W-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= pwdata[SCR_W-1:0];
                REG_LINE_PITCH:    cfg_reg.line_pitch    <= pwdata[PITCH_W-1:0];
                REG_MARGIN:        cfg_reg.margin        <= pwdata[MARGIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_FG_COLOR:      prdata = cfg_reg.fg_color;
            REG_BG_COLOR:      prdata = cfg_reg.bg_color;
            REG_SCREEN_WIDTH:  prdata = PDATA_W'(cfg_reg.screen_width);
            REG_SCREEN_HEIGHT: prdata = PDATA_W'(cfg_reg.screen_height);
            REG_LINE_PITCH:    prdata = PDATA_W'(cfg_reg.line_pitch);
            REG_MARGIN:        prdata = PDATA_W'(cfg_reg.margin);
            default:           prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/bitmap_text_console_renderer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Put character: accept, multiply, base add, then one row beat per glyph row, one more
// beat when the line wrap clears the screen. Backspace: the same steps with fill beats.
// Clear screen: accept, then a single clear beat; glyph load and plain newline: accept only.
// Row rate is set by the single read port of the font store: one glyph row per cycle unless out_stall holds it.
// Reset (rst_n, async): registers to their defaults, cursor to the default margin,
// output empty; font store contents stay undefined until loaded, no clearing pass.
// ---------------------------------------------------------------------------
// bitmap_text_console_renderer_unit
// Text console sequencer: reads glyph rows from the font store, emits
// masked row writes, backspace fills and screen clears, keeps the cursor.
// ---------------------------------------------------------------------------
module bitmap_text_console_renderer_unit
    import bmtc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [CMD_W-1:0]       cmd,
    input  wire logic [CODE_W-1:0]      char_code,
    input  wire logic [GROW_W-1:0]      glyph_row,
    input  wire logic [BITS_W-1:0]      row_bits,
    // output channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [KIND_W-1:0]           kind,
    output logic [OFF_W-1:0]            pixel_offset,
    output logic [GLYPH_WIDTH-1:0]      pixel_mask,
    output logic [COLOR_W-1:0]          pixel_color,
    output logic                        last_result,
    // configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]          prdata,
    output logic                        pready
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CALC  = 5'b00010,
        ST_BASE  = 5'b00100,
        ST_ROWS  = 5'b01000,
        ST_CLEAR = 5'b10000
    } state_t;

    cfg_t              cfg;
    font_req_t         font_req;
    logic [BITS_W-1:0] font_rdata;

    state_t               state_reg, state_next;
    logic [CUR_W-1:0]     cx_reg, cx_next;
    logic [CUR_W-1:0]     cy_reg, cy_next;
    logic [RCNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic [ROW_W-1:0]     em_cnt_reg, em_cnt_next;
    logic                 pend_reg, pend_next;
    logic                 clr_reg, clr_next;
    logic                 ov_reg, ov_next;

    // item payload
    logic [CODE_W-1:0]    code_reg;
    logic                 fill_reg;
    logic                 glyph_ok_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [OFF_W-1:0]     off_reg, off_next;

    // output beat
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [OFF_W-1:0]       ooff_reg, ooff_next;
    logic [GLYPH_WIDTH-1:0] omask_reg, omask_next;
    logic [COLOR_W-1:0]     ocol_reg, ocol_next;
    logic                   olast_reg, olast_next;
    logic                   load_beat;

    logic in_acc;
    logic out_free;
    logic emit_row;
    logic issue;
    logic load_ok;
    logic glyph_ok;
    logic row_last;

    // cursor arithmetic
    logic [CUR_W-1:0] y_nl;
    logic             nl_clr;
    logic [CUR_W-1:0] cx_adv;
    logic             wrap;
    logic             bk_under;
    logic [CMP_W-1:0] span;
    logic             cells_ok;
    logic [CUR_W-1:0] bk_x;
    logic [CUR_W-1:0] bk_y;

    // screen full test for a new text row at y
    function automatic logic nl_clear(input logic [CUR_W-1:0] y,
                                      input logic [MARGIN_W-1:0] m,
                                      input logic [SCR_W-1:0] sh);
        logic [CMP_W-1:0] lhs;
        lhs = CMP_W'(y) + CMP_W'(GLYPH_ROWS) + CMP_W'(m);
        return lhs > CMP_W'(sh);
    endfunction

    bmtc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmtc_font_ram u_font (
        .clk   (clk),
        .req   (font_req),
        .rdata (font_rdata)
    );

    // handshake
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !ov_reg || !out_stall;

    assign load_ok  = (32'(char_code) < 32'(GLYPH_COUNT)) &&
                      (32'(glyph_row) < 32'(GLYPH_ROWS));
    assign glyph_ok = 32'(char_code) < 32'(GLYPH_COUNT);

    // row pipeline: a read is issued only when its data can land in the
    // ram output register without overwriting a row still waiting
    assign emit_row = (state_reg == ST_ROWS) && pend_reg && out_free;
    assign issue    = ((state_reg == ST_CALC) || (state_reg == ST_BASE) ||
                       (state_reg == ST_ROWS)) &&
                      (rd_cnt_reg != RCNT_W'(GLYPH_ROWS)) &&
                      (!pend_reg || emit_row);
    assign row_last = (em_cnt_reg == ROW_W'(GLYPH_ROWS - 1));

    // font store access: glyph loads only in idle, reads only while busy
    always_comb
    begin
        font_req.we    = in_acc && (cmd == CMD_LOAD) && load_ok;
        font_req.re    = issue;
        font_req.wdata = row_bits;
        if (state_reg == ST_IDLE)
        begin
            font_req.addr = FONT_AW'(32'(char_code) * GLYPH_ROWS + 32'(glyph_row));
        end
        else
        begin
            font_req.addr = FONT_AW'(32'(code_reg) * GLYPH_ROWS +
                                     32'(rd_cnt_reg[ROW_W-1:0]));
        end
    end

    // newline and advance
    assign y_nl   = cy_reg + CUR_W'(GLYPH_ROWS);
    assign nl_clr = nl_clear(y_nl, cfg.margin, cfg.screen_height);
    assign cx_adv = cx_reg + CUR_W'(GLYPH_WIDTH);
    assign wrap   = (CMP_W'(cx_adv) + CMP_W'(GLYPH_WIDTH) + CMP_W'(cfg.margin)) >
                    CMP_W'(cfg.screen_width);

    // backspace with wrap to the last cell of the previous line
    assign bk_under = CMP_W'(cx_reg) < (CMP_W'(cfg.margin) + CMP_W'(GLYPH_WIDTH));
    assign span     = CMP_W'(cfg.screen_width) - CMP_W'({cfg.margin, 1'b0});
    assign cells_ok = !span[CMP_W-1] && (span >= CMP_W'(GLYPH_WIDTH));
    assign bk_x     = cells_ok
                      ? CUR_W'(CMP_W'(cfg.margin) + (span & ~CMP_W'(GLYPH_WIDTH - 1)) -
                               CMP_W'(GLYPH_WIDTH))
                      : CUR_W'(cfg.margin);
    assign bk_y     = (CMP_W'(cy_reg) < (CMP_W'(cfg.margin) + CMP_W'(GLYPH_ROWS)))
                      ? CUR_W'(cfg.margin)
                      : cy_reg - CUR_W'(GLYPH_ROWS);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        clr_next    = clr_reg;
        off_next    = off_reg;
        em_cnt_next = em_cnt_reg;
        rd_cnt_next = issue ? rd_cnt_reg + RCNT_W'(1) : rd_cnt_reg;
        if (issue)
        begin
            pend_next = 1'b1;
        end
        else if (emit_row)
        begin
            pend_next = 1'b0;
        end
        else
        begin
            pend_next = pend_reg;
        end
        ov_next    = ov_reg && out_stall;
        load_beat  = 1'b0;
        kind_next  = KIND_CLEAR;
        ooff_next  = '0;
        omask_next = '0;
        ocol_next  = cfg.bg_color;
        olast_next = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rd_cnt_next = '0;
                    em_cnt_next = '0;
                    pend_next   = 1'b0;
                    clr_next    = 1'b0;
                    case (cmd)
                        CMD_LOAD:
                        begin
                            state_next = ST_IDLE;
                        end
                        CMD_CLEAR:
                        begin
                            cx_next    = CUR_W'(cfg.margin);
                            cy_next    = CUR_W'(cfg.margin);
                            state_next = ST_CLEAR;
                        end
                        CMD_PUT:
                        begin
                            if (char_code == NEWLINE_CODE)
                            begin
                                cx_next = CUR_W'(cfg.margin);
                                if (nl_clr)
                                begin
                                    cy_next    = CUR_W'(cfg.margin);
                                    state_next = ST_CLEAR;
                                end
                                else
                                begin
                                    cy_next = y_nl;
                                end
                            end
                            else
                            begin
                                state_next = ST_CALC;
                            end
                        end
                        CMD_BKSP:
                        begin
                            if (bk_under)
                            begin
                                cx_next = bk_x;
                                cy_next = bk_y;
                            end
                            else
                            begin
                                cx_next = cx_reg - CUR_W'(GLYPH_WIDTH);
                            end
                            state_next = ST_CALC;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CALC:
            begin
                state_next = ST_BASE;
            end

            ST_BASE:
            begin
                off_next = OFF_W'(cx_reg) + prod_reg[OFF_W-1:0];
                // a character moves the cursor once its cell offset is fixed
                if (!fill_reg)
                begin
                    if (wrap)
                    begin
                        cx_next = CUR_W'(cfg.margin);
                        if (nl_clr)
                        begin
                            cy_next  = CUR_W'(cfg.margin);
                            clr_next = 1'b1;
                        end
                        else
                        begin
                            cy_next = y_nl;
                        end
                    end
                    else
                    begin
                        cx_next = cx_adv;
                    end
                end
                state_next = ST_ROWS;
            end

            ST_ROWS:
            begin
                if (emit_row)
                begin
                    load_beat   = 1'b1;
                    ooff_next   = off_reg;
                    olast_next  = row_last && !clr_reg;
                    if (fill_reg)
                    begin
                        kind_next  = KIND_FILL;
                        omask_next = MASK_ALL;
                        ocol_next  = cfg.bg_color;
                    end
                    else
                    begin
                        kind_next  = KIND_GLYPH;
                        omask_next = glyph_ok_reg ? font_rdata : '0;
                        ocol_next  = cfg.fg_color;
                    end
                    off_next    = off_reg + OFF_W'(cfg.line_pitch);
                    em_cnt_next = em_cnt_reg + ROW_W'(1);
                    if (row_last)
                    begin
                        state_next = clr_reg ? ST_CLEAR : ST_IDLE;
                    end
                end
            end

            ST_CLEAR:
            begin
                if (out_free)
                begin
                    load_beat  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_beat)
        begin
            ov_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cx_reg     <= CUR_W'(MARGIN_RST);
            cy_reg     <= CUR_W'(MARGIN_RST);
            rd_cnt_reg <= '0;
            em_cnt_reg <= '0;
            pend_reg   <= 1'b0;
            clr_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            rd_cnt_reg <= rd_cnt_next;
            em_cnt_reg <= em_cnt_next;
            pend_reg   <= pend_next;
            clr_reg    <= clr_next;
            ov_reg     <= ov_next;
        end
    end

    // item and beat payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            code_reg     <= char_code;
            fill_reg     <= (cmd == CMD_BKSP);
            glyph_ok_reg <= glyph_ok;
        end
        if (state_reg == ST_CALC)
        begin
            prod_reg <= PROD_W'(cy_reg) * PROD_W'(cfg.line_pitch);
        end
        off_reg <= off_next;
        if (load_beat)
        begin
            kind_reg  <= kind_next;
            ooff_reg  <= ooff_next;
            omask_reg <= omask_next;
            ocol_reg  <= ocol_next;
            olast_reg <= olast_next;
        end
    end

    assign out_valid    = ov_reg;
    assign kind         = kind_reg;
    assign pixel_offset = ooff_reg;
    assign pixel_mask   = omask_reg;
    assign pixel_color  = ocol_reg;
    assign last_result  = olast_reg;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap text console renderer. A queued driver
// offers command beats, a clocked monitor predicts the pixel writes of each
// accepted beat from its own copy of the font store, cursor and registers,
// and compares every result beat against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
    import bmtc_pkg::*;

    localparam int     HALF_PERIOD   = 5;
    localparam int     SETTLE_CYCLES = 30;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     REPORT_LIMIT  = 40;
    localparam longint TIMEOUT_NS    = 8_000_000;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [CODE_W-1:0] code;
        logic [GROW_W-1:0] row;
        logic [BITS_W-1:0] bits;
    } console_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [OFF_W-1:0]       offset;
        logic [GLYPH_WIDTH-1:0] mask;
        logic [COLOR_W-1:0]     color;
        logic                   last;
    } pixel_op_t;

    // clock, reset and block ports
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [CMD_W-1:0]       cmd       = CMD_PUT;
    logic [CODE_W-1:0]      char_code = '0;
    logic [GROW_W-1:0]      glyph_row = '0;
    logic [BITS_W-1:0]      row_bits  = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [KIND_W-1:0]      kind;
    logic [OFF_W-1:0]       pixel_offset;
    logic [GLYPH_WIDTH-1:0] pixel_mask;
    logic [COLOR_W-1:0]     pixel_color;
    logic                   last_result;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [PADDR_W-1:0]     paddr     = '0;
    logic [PDATA_W-1:0]     pwdata    = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    // stimulus side
    console_cmd_t           pending_cmds[$];
    bit [GLYPH_ROWS-1:0]    rows_queued [GLYPH_COUNT];
    logic [CODE_W-1:0]      drawable[$];
    logic                   in_took        = 1'b0;
    int                     send_idle_pct  = 24;
    int                     recv_stall_pct = 84;
    int                     hold_reqs      = 0;
    int                     hold_served    = 0;
    int                     hold_left      = 0;

    // prediction side
    cfg_t                   shadow_cfg;
    logic [BITS_W-1:0]      font_shadow [FONT_DEPTH];
    logic [CUR_W-1:0]       cur_x;
    logic [CUR_W-1:0]       cur_y;
    pixel_op_t              expected_ops[$];

    int                     mismatches      = 0;
    int                     results_checked = 0;
    int                     items_accepted  = 0;
    int                     settings_run    = 0;

    bitmap_text_console_renderer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .char_code    (char_code),
        .glyph_row    (glyph_row),
        .row_bits     (row_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .pixel_offset (pixel_offset),
        .pixel_mask   (pixel_mask),
        .pixel_color  (pixel_color),
        .last_result  (last_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock
    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // console model
    // ---------------------------------------------------------------------

    function automatic logic [OFF_W-1:0] cell_offset(input int row);
        longint o;
        o = longint'(cur_x) + (longint'(cur_y) + row) * longint'(shadow_cfg.line_pitch);
        return o[OFF_W-1:0];
    endfunction

    function automatic void home_cursor();
        cur_x = CUR_W'(shadow_cfg.margin);
        cur_y = CUR_W'(shadow_cfg.margin);
    endfunction

    // returns 1 when the next text row does not fit and the screen is cleared
    function automatic bit advance_line();
        cur_x = CUR_W'(shadow_cfg.margin);
        cur_y = cur_y + CUR_W'(GLYPH_ROWS);
        if (longint'(cur_y) + GLYPH_ROWS + longint'(shadow_cfg.margin)
            > longint'(shadow_cfg.screen_height))
        begin
            home_cursor();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_op(input logic [KIND_W-1:0] k, input logic [OFF_W-1:0] off,
                                   input logic [GLYPH_WIDTH-1:0] m,
                                   input logic [COLOR_W-1:0] colour);
        pixel_op_t p;
        p.kind   = k;
        p.offset = off;
        p.mask   = m;
        p.color  = colour;
        p.last   = 1'b0;
        expected_ops.push_back(p);
    endfunction

    task automatic predict_console_item(input console_cmd_t c);
        longint    nx;
        longint    ny;
        longint    cells;
        pixel_op_t tail;
        int        n;
        bit        wrapped;
        n       = 0;
        wrapped = 1'b0;
        case (c.op)
            CMD_LOAD:
                font_shadow[int'(c.code) * GLYPH_ROWS + int'(c.row)] = c.bits;
            CMD_CLEAR:
            begin
                add_op(KIND_CLEAR, '0, '0, shadow_cfg.bg_color);
                n++;
                home_cursor();
            end
            CMD_PUT:
            begin
                if (c.code == NEWLINE_CODE)
                    wrapped = advance_line();
                else
                begin
                    for (int r = 0; r < GLYPH_ROWS; r++)
                    begin
                        add_op(KIND_GLYPH, cell_offset(r),
                               font_shadow[int'(c.code) * GLYPH_ROWS + r], shadow_cfg.fg_color);
                        n++;
                    end
                    cur_x = cur_x + CUR_W'(GLYPH_WIDTH);
                    // wrap at the right margin, compared signed
                    if (longint'(cur_x) + GLYPH_WIDTH
                        > longint'(shadow_cfg.screen_width) - longint'(shadow_cfg.margin))
                        wrapped = advance_line();
                end
                if (wrapped)
                begin
                    add_op(KIND_CLEAR, '0, '0, shadow_cfg.bg_color);
                    n++;
                end
            end
            CMD_BKSP:
            begin
                nx = longint'(cur_x) - GLYPH_WIDTH;
                // step back past the left margin: end of the line above, clamped at the top
                if (nx < longint'(shadow_cfg.margin))
                begin
                    cells = (longint'(shadow_cfg.screen_width)
                             - 2 * longint'(shadow_cfg.margin)) / GLYPH_WIDTH;
                    if (cells < 1)
                        nx = longint'(shadow_cfg.margin);
                    else
                        nx = longint'(shadow_cfg.margin) + GLYPH_WIDTH * (cells - 1);
                    ny = longint'(cur_y) - GLYPH_ROWS;
                    if (ny < longint'(shadow_cfg.margin))
                        ny = longint'(shadow_cfg.margin);
                    cur_y = ny[CUR_W-1:0];
                end
                cur_x = nx[CUR_W-1:0];
                for (int r = 0; r < GLYPH_ROWS; r++)
                begin
                    add_op(KIND_FILL, cell_offset(r), MASK_ALL, shadow_cfg.bg_color);
                    n++;
                end
            end
            default: ;
        endcase
        // flag the final write of this command
        if (n > 0)
        begin
            tail      = expected_ops.pop_back();
            tail.last = 1'b1;
            expected_ops.push_back(tail);
        end
    endtask

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [CODE_W-1:0] code,
                             input logic [GROW_W-1:0] row, input logic [BITS_W-1:0] bits);
        console_cmd_t c;
        c.op   = op;
        c.code = code;
        c.row  = row;
        c.bits = bits;
        pending_cmds.push_back(c);
        // a glyph becomes drawable once all of its rows are loaded
        if (op == CMD_LOAD && !(&rows_queued[code]))
        begin
            rows_queued[code][row] = 1'b1;
            if (&rows_queued[code])
                drawable.push_back(code);
        end
    endtask

    task automatic queue_glyph(input logic [CODE_W-1:0] code);
        for (int r = 0; r < GLYPH_ROWS; r++)
            queue_cmd(CMD_LOAD, code, GROW_W'(r), BITS_W'($urandom));
    endtask

    // mostly drawing with loaded glyphs, some font loads, edits and stray rows
    task automatic queue_console_traffic(input int n);
        int added;
        int pick;
        added = 0;
        while (added < n)
        begin
            pick = $urandom_range(0, 99);
            if (drawable.size() == 0 || pick < 5)
            begin
                queue_glyph(CODE_W'($urandom));
                added += GLYPH_ROWS;
            end
            else if (pick < 10)
            begin
                queue_cmd(CMD_LOAD, CODE_W'($urandom), GROW_W'($urandom), BITS_W'($urandom));
                added++;
            end
            else if (pick < 65)
            begin
                queue_cmd(CMD_PUT, drawable[$urandom_range(0, drawable.size() - 1)],
                          GROW_W'($urandom), BITS_W'($urandom));
                added++;
            end
            else if (pick < 75)
            begin
                queue_cmd(CMD_PUT, NEWLINE_CODE, GROW_W'($urandom), BITS_W'($urandom));
                added++;
            end
            else if (pick < 92)
            begin
                queue_cmd(CMD_BKSP, CODE_W'($urandom), GROW_W'($urandom), BITS_W'($urandom));
                added++;
            end
            else
            begin
                queue_cmd(CMD_CLEAR, CODE_W'($urandom), GROW_W'($urandom), BITS_W'($urandom));
                added++;
            end
        end
    endtask

    // register write: setup then access, mirrored into the model afterwards
    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [PDATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FG_COLOR:      shadow_cfg.fg_color      = val;
            REG_BG_COLOR:      shadow_cfg.bg_color      = val;
            REG_SCREEN_WIDTH:  shadow_cfg.screen_width  = val[SCR_W-1:0];
            REG_SCREEN_HEIGHT: shadow_cfg.screen_height = val[SCR_W-1:0];
            REG_LINE_PITCH:    shadow_cfg.line_pitch    = val[PITCH_W-1:0];
            REG_MARGIN:        shadow_cfg.margin        = val[MARGIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_random_settings();
        write_reg(REG_FG_COLOR, $urandom);
        write_reg(REG_BG_COLOR, $urandom);
        write_reg(REG_SCREEN_WIDTH, $urandom_range(16, 4096));
        write_reg(REG_SCREEN_HEIGHT, $urandom_range(32, 4096));
        write_reg(REG_LINE_PITCH, $urandom_range(16, 8192));
        write_reg(REG_MARGIN, $urandom_range(0, 64));
        settings_run++;
    endtask

    // all beats accepted and all writes seen, then room for result-free commands
    task automatic wait_quiet();
        while (pending_cmds.size() != 0 || in_valid || expected_ops.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // ---------------------------------------------------------------------
    // command driver
    // ---------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_commands
        console_cmd_t next_cmd;
        if (rst_n && (!in_valid || in_took))
        begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_cmd   = pending_cmds.pop_front();
                in_valid  <= 1'b1;
                cmd       <= next_cmd.op;
                char_code <= next_cmd.code;
                glyph_row <= next_cmd.row;
                row_bits  <= next_cmd.bits;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // result back-pressure, with an occasional long hold-off
    // ---------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_reqs != hold_served)
        begin
            hold_served = hold_reqs;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ---------------------------------------------------------------------
    // monitor: check result beats, predict from accepted command beats
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        pixel_op_t    want;
        console_cmd_t taken;
        if (rst_n)
        begin
            in_took <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (expected_ops.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected pixel write, expected none, got kind %0d offset 0x%0h",
                                 $time, kind, pixel_offset);
                end
                else
                begin
                    want = expected_ops.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("pixel_offset", want.offset, pixel_offset);
                    check_field("pixel_mask", want.mask, pixel_mask);
                    check_field("pixel_color", want.color, pixel_color);
                    check_field("last_result", want.last, last_result);
                end
            end
            if (in_valid && !in_stall)
            begin
                taken.op   = cmd;
                taken.code = char_code;
                taken.row  = glyph_row;
                taken.bits = row_bits;
                items_accepted++;
                predict_console_item(taken);
            end
        end
    end

    // ---------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------
    initial
    begin
        shadow_cfg = {FG_RST, BG_RST, WIDTH_RST, HEIGHT_RST, PITCH_RST, MARGIN_RST};
        cur_x      = CUR_W'(MARGIN_RST);
        cur_y      = CUR_W'(MARGIN_RST);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset settings: one glyph with edge row patterns, then each command
        settings_run++;
        for (int r = 0; r < GLYPH_ROWS; r++)
            queue_cmd(CMD_LOAD, 8'hff, GROW_W'(r),
                      (r == 0) ? 8'h00 : (r == 1) ? 8'hff : (r == 2) ? 8'h80 :
                      (r == 3) ? 8'h01 : BITS_W'($urandom));
        // backspace at home wraps to the line above and clamps at the top
        queue_cmd(CMD_BKSP, 8'h00, 4'h0, 8'h00);
        queue_cmd(CMD_PUT, 8'hff, 4'hf, 8'hff);
        queue_cmd(CMD_PUT, 8'hff, 4'h0, 8'h00);
        queue_cmd(CMD_BKSP, 8'hff, 4'hf, 8'hff);
        // newline with room left gives no write
        queue_cmd(CMD_PUT, NEWLINE_CODE, 4'h5, 8'h5a);
        queue_cmd(CMD_PUT, 8'hff, 4'ha, 8'ha5);
        queue_cmd(CMD_CLEAR, 8'hff, 4'hf, 8'hff);
        queue_cmd(CMD_PUT, 8'hff, 4'h0, 8'h00);
        wait_quiet();

        // random settings
        program_random_settings();
        queue_glyph(8'h00);
        queue_console_traffic(25);
        wait_quiet();

        // narrowest and shortest screen, no margin
        send_idle_pct  = 84;
        recv_stall_pct = 24;
        write_reg(REG_FG_COLOR, 32'h0000_0000);
        write_reg(REG_BG_COLOR, 32'hffff_ffff);
        write_reg(REG_SCREEN_WIDTH, 32'd16);
        write_reg(REG_SCREEN_HEIGHT, 32'd32);
        write_reg(REG_LINE_PITCH, 32'd16);
        write_reg(REG_MARGIN, 32'd0);
        settings_run++;
        queue_console_traffic(20);
        wait_quiet();

        // margins wider than the screen: wrap and clear on every character
        write_reg(REG_MARGIN, 32'd64);
        settings_run++;
        queue_console_traffic(20);
        wait_quiet();

        // largest screen and pitch; walk the cursor well down the screen first
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_FG_COLOR, 32'hffff_ffff);
        write_reg(REG_BG_COLOR, 32'h0000_0000);
        write_reg(REG_SCREEN_WIDTH, 32'd4096);
        write_reg(REG_SCREEN_HEIGHT, 32'd4096);
        write_reg(REG_LINE_PITCH, 32'd8192);
        write_reg(REG_MARGIN, 32'd64);
        settings_run++;
        repeat (40) queue_cmd(CMD_PUT, NEWLINE_CODE, GROW_W'($urandom), BITS_W'($urandom));
        wait_quiet();
        queue_console_traffic(25);
        hold_reqs++;
        wait_quiet();

        // random settings again, no idling
        program_random_settings();
        queue_console_traffic(25);
        wait_quiet();

        $display("checked %0d pixel writes produced by %0d accepted commands",
                 results_checked, items_accepted);
        $display("covered %0d register settings, from reset values to the narrowest %s",
                 settings_run, "and largest screens");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: run did not complete, %0d pixel writes still outstanding",
                 $time, expected_ops.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/bmtc_pkg.sv
design/bmtc_font_ram.sv
design/bmtc_cfg_regs.sv
design/bitmap_text_console_renderer_unit.sv
tb/testbench.sv
